FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks that compile away under NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, pre, post)

`define ASSERT_NEXT(lbl, clk, rst, pre, post)

`endif

`endif

FILE: hw/rtl/cbcrtc_pkg.sv
// ---------------------------------------------------------------------------
// cbcrtc_pkg
// Sizes, request codes, field layout and memory port bundle of the bank
// controller.
// ---------------------------------------------------------------------------
`default_nettype none

package cbcrtc_pkg;

   localparam int ROM_BANKS      = 128;
   localparam int RAM_BANKS      = 4;
   localparam int ROM_BANK_BYTES = 16384;
   localparam int RAM_BANK_BYTES = 8192;

   localparam int ROM_TOTAL  = ROM_BANKS * ROM_BANK_BYTES;
   localparam int RAM_TOTAL  = RAM_BANKS * RAM_BANK_BYTES;
   localparam int ROM_OFF_W  = $clog2(ROM_BANK_BYTES);
   localparam int RAM_OFF_W  = $clog2(RAM_BANK_BYTES);
   localparam int ROM_BANK_W = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
   localparam int RAM_BANK_W = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
   localparam int ROM_ADDR_W = $clog2(ROM_TOTAL);
   localparam int RAM_ADDR_W = $clog2(RAM_TOTAL);

   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;

   localparam logic [1:0] REQ_READ    = 2'd0;
   localparam logic [1:0] REQ_WRITE   = 2'd1;
   localparam logic [1:0] REQ_PRELOAD = 2'd2;

   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_ROMBNK = 3'd1;
   localparam logic [2:0] REG_SELECT = 3'd2;
   localparam logic [2:0] REG_LATCH  = 3'd3;
   localparam logic [2:0] REG_WINDOW = 3'd5;

   localparam logic [7:0] ENABLE_KEY  = 8'h0A;
   localparam logic [7:0] LATCH_KEY   = 8'h01;
   localparam logic [7:0] SEL_RTC_LO  = 8'h04;
   localparam logic [7:0] SEL_NONE_LO = 8'h0D;
   localparam logic [7:0] OPEN_BUS    = 8'hFF;

   localparam logic [3:0] RTC_SEC  = 4'h8;
   localparam logic [3:0] RTC_MIN  = 4'h9;
   localparam logic [3:0] RTC_HOUR = 4'hA;
   localparam logic [3:0] RTC_DAYL = 4'hB;
   localparam logic [3:0] RTC_DAYH = 4'hC;

   typedef struct packed {
      logic                  rom_we;
      logic                  rom_re;
      logic [ROM_ADDR_W-1:0] rom_addr;
      logic                  ram_we;
      logic                  ram_re;
      logic [RAM_ADDR_W-1:0] ram_addr;
      logic [7:0]            wdata;
   } mem_req_type;

   function automatic logic [ROM_BANK_W-1:0] rom_bank_wrap(input logic [6:0] b);
      logic [ROM_BANK_W-1:0] r;
      r = '0;
      for (int i = 0; i < 128; i++) begin
         if (b == 7'(i)) r = ROM_BANK_W'(i % ROM_BANKS);
      end
      return r;
   endfunction

   function automatic logic [RAM_BANK_W-1:0] ram_bank_wrap(input logic [1:0] b);
      logic [RAM_BANK_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         if (b == 2'(i)) r = RAM_BANK_W'(i % RAM_BANKS);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cbcrtc_store.sv
// ---------------------------------------------------------------------------
// cbcrtc_store
// ROM image and banked save RAM, each one write or one registered read
// per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cbcrtc_store (
   input  wire logic                     clock,
   input  wire cbcrtc_pkg::mem_req_type  mem_req,
   output logic [7:0]                    rom_q,
   output logic [7:0]                    ram_q
);
   import cbcrtc_pkg::*;

   logic [7:0] rom_mem [ROM_TOTAL];
   logic [7:0] ram_mem [RAM_TOTAL];

   always_ff @(posedge clock) begin
      if (mem_req.rom_we) begin
         rom_mem[mem_req.rom_addr] <= mem_req.wdata;
      end
      if (mem_req.rom_re) begin
         rom_q <= rom_mem[mem_req.rom_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.ram_we) begin
         ram_mem[mem_req.ram_addr] <= mem_req.wdata;
      end
      if (mem_req.ram_re) begin
         ram_q <= ram_mem[mem_req.ram_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/cartridge_bank_controller_rtc.sv
// ---------------------------------------------------------------------------
// cartridge_bank_controller_rtc
// Bank controller with clock latch: decodes bus beats, keeps bank and clock
// registers, and serves reads from the ROM image and save RAM.
//
//   Channel  Ports                          Carries
//   req      req_tvalid/tready/tdata/tuser  bus read, bus write, ROM preload
//   rsp      rsp_tvalid/tready/tdata        read byte, one per bus read
//
// One beat accepted per cycle while req_tready is high; a read passes the
// s1 stage and then the rsp register. The rate is set by the single port of
// each memory, used once per beat. After reset the save RAM is swept to
// zero, one entry per cycle (RAM_TOTAL = 32768), with req_tready low.
// A stalled rsp holds the read stage; req_tready also drops when both fill.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cartridge_bank_controller_rtc (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // bus_address[15:0], data_byte[23:16], rom_load_address[44:24],
   // now_seconds[50:45], now_minutes[56:51], now_hours[61:57],
   // now_days[70:62], zero pad[71]
   input  wire logic [cbcrtc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[1:0]
   input  wire logic [cbcrtc_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // read_data[7:0]
   output logic [cbcrtc_pkg::RSP_DATA_W-1:0]           rsp_tdata
);
   import cbcrtc_pkg::*;

   typedef enum logic [1:0] {WIN_RAM, WIN_RTC, WIN_NONE} win_type;
   typedef enum logic [1:0] {SRC_ROM, SRC_RAM, SRC_CONST} src_type;

   logic [15:0] bus_address;
   logic [7:0]  data_byte;
   logic [20:0] rom_load_address;
   logic [5:0]  now_seconds;
   logic [5:0]  now_minutes;
   logic [4:0]  now_hours;
   logic [8:0]  now_days;

   assign bus_address      = req_tdata[15:0];
   assign data_byte        = req_tdata[23:16];
   assign rom_load_address = req_tdata[44:24];
   assign now_seconds      = req_tdata[50:45];
   assign now_minutes      = req_tdata[56:51];
   assign now_hours        = req_tdata[61:57];
   assign now_days         = req_tdata[70:62];

   logic                  ram_enabled_ff;
   logic [ROM_BANK_W-1:0] rom_bank_ff;
   logic [RAM_BANK_W-1:0] ram_bank_ff;
   logic [3:0]            clock_select_ff;
   win_type               window_mode_ff;
   logic [5:0]            latched_seconds_ff;
   logic [5:0]            latched_minutes_ff;
   logic [4:0]            latched_hours_ff;
   logic [8:0]            latched_days_ff;

   logic                  clr_busy_ff;
   logic [RAM_ADDR_W-1:0] clr_cnt_ff;

   logic                  s1_valid_ff;
   src_type               s1_src_ff;
   logic [7:0]            s1_const_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff;

   logic                  accept;
   logic                  s1_adv;
   logic                  is_read;
   logic                  is_write;
   logic [2:0]            region;
   logic [6:0]            bank_in;
   logic [7:0]            clock_value;
   src_type               s1_src_in;
   logic [7:0]            s1_const_in;
   mem_req_type           mem_req;
   logic [7:0]            rom_q;
   logic [7:0]            ram_q;
   logic [ROM_OFF_W+ROM_BANK_W-1:0] rom_rd_pos;
   logic [RAM_OFF_W+RAM_BANK_W-1:0] ram_pos;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;
   assign is_read    = accept && (req_tuser == REQ_READ);
   assign is_write   = accept && (req_tuser == REQ_WRITE);
   assign region     = bus_address[15:13];
   assign bank_in    = (data_byte[6:0] == 7'd0) ? 7'd1 : data_byte[6:0];

   assign rom_rd_pos = bus_address[14] ? {rom_bank_ff, bus_address[ROM_OFF_W-1:0]}
                                       : {ROM_BANK_W'(0), bus_address[ROM_OFF_W-1:0]};
   assign ram_pos    = {ram_bank_ff, bus_address[RAM_OFF_W-1:0]};

   always_comb begin
      case (clock_select_ff)
         RTC_SEC:  clock_value = {2'd0, latched_seconds_ff};
         RTC_MIN:  clock_value = {2'd0, latched_minutes_ff};
         RTC_HOUR: clock_value = {3'd0, latched_hours_ff};
         RTC_DAYL: clock_value = latched_days_ff[7:0];
         RTC_DAYH: clock_value = {7'd0, latched_days_ff[8]};
         default:  clock_value = 8'd0;
      endcase
   end

   always_comb begin
      mem_req          = '0;
      mem_req.rom_addr = ROM_ADDR_W'(rom_rd_pos);
      mem_req.ram_addr = RAM_ADDR_W'(ram_pos);
      mem_req.wdata    = data_byte;
      s1_src_in        = SRC_CONST;
      s1_const_in      = OPEN_BUS;
      if (clr_busy_ff) begin
         mem_req.ram_we   = 1'b1;
         mem_req.ram_addr = clr_cnt_ff;
         mem_req.wdata    = 8'd0;
      end else if (is_read) begin
         if (!bus_address[15]) begin
            mem_req.rom_re = 1'b1;
            s1_src_in      = SRC_ROM;
         end else if (region == REG_WINDOW && ram_enabled_ff) begin
            if (window_mode_ff == WIN_RAM) begin
               mem_req.ram_re = 1'b1;
               s1_src_in      = SRC_RAM;
            end else if (window_mode_ff == WIN_RTC) begin
               s1_const_in = clock_value;
            end
         end
      end else if (is_write) begin
         mem_req.ram_we = (region == REG_WINDOW) && ram_enabled_ff
                          && (window_mode_ff == WIN_RAM);
      end else if (accept && req_tuser == REQ_PRELOAD) begin
         mem_req.rom_we   = (32'(rom_load_address) < 32'(ROM_TOTAL));
         mem_req.rom_addr = rom_load_address[ROM_ADDR_W-1:0];
      end
   end

   cbcrtc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rom_q   (rom_q),
      .ram_q   (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == RAM_ADDR_W'(RAM_TOTAL - 1)) clr_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enabled_ff     <= 1'b0;
         rom_bank_ff        <= ROM_BANK_W'(1);
         ram_bank_ff        <= '0;
         clock_select_ff    <= '0;
         window_mode_ff     <= WIN_RAM;
         latched_seconds_ff <= '0;
         latched_minutes_ff <= '0;
         latched_hours_ff   <= '0;
         latched_days_ff    <= '0;
      end else if (is_write) begin
         case (region)
            REG_ENABLE: ram_enabled_ff <= (data_byte == ENABLE_KEY);
            REG_ROMBNK: rom_bank_ff    <= rom_bank_wrap(bank_in);
            REG_SELECT: begin
               if (data_byte < SEL_RTC_LO) begin
                  window_mode_ff <= WIN_RAM;
                  ram_bank_ff    <= ram_bank_wrap(data_byte[1:0]);
               end else if (data_byte < SEL_NONE_LO) begin
                  window_mode_ff  <= WIN_RTC;
                  clock_select_ff <= data_byte[3:0];
               end else begin
                  window_mode_ff <= WIN_NONE;
               end
            end
            REG_LATCH: begin
               if (data_byte == LATCH_KEY) begin
                  latched_seconds_ff <= now_seconds;
                  latched_minutes_ff <= now_minutes;
                  latched_hours_ff   <= now_hours;
                  latched_days_ff    <= now_days;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (is_read) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_read) begin
         s1_src_ff   <= s1_src_in;
         s1_const_ff <= s1_const_in;
      end
      if (s1_adv) begin
         case (s1_src_ff)
            SRC_ROM: rsp_data_ff <= rom_q;
            SRC_RAM: rsp_data_ff <= ram_q;
            default: rsp_data_ff <= s1_const_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLY(a_no_accept_in_clear, clock, reset, clr_busy_ff, !req_tready)
   `ASSERT_NEXT(a_read_enters_stage, clock, reset, is_read, s1_valid_ff)
   `ASSERT_NEXT(a_stage_holds_on_stall, clock, reset,
                s1_valid_ff && rsp_valid_ff && !rsp_tready, s1_valid_ff)
   `ASSERT_NEXT(a_stage_feeds_output, clock, reset, s1_adv, rsp_valid_ff)

endmodule

`default_nettype wire

FILE: dv/cartridge_bank_controller_rtc_test.sv
// ---------------------------------------------------------------------------
// cartridge_bank_controller_rtc_test
// Self-checking bench for the bank controller with clock latch. A queue of
// bus reads, bus writes and ROM preload beats feeds a falling-edge driver.
// Each accepted beat runs through a local model of the bank, window and
// latch registers, the save RAM and the ROM image. Every read byte is
// checked in order against the model's answer. The stimulus opens with
// directed corner cases, then runs random enable, bank, RAM, clock and noise
// sequences. Only ROM bytes that a preload wrote are ever read. Both
// channels idle in random bursts, and the sender waits for all reads to
// drain at fixed points.
// ---------------------------------------------------------------------------
module cartridge_bank_controller_rtc_test;
   import cbcrtc_pkg::*;

   localparam logic [1:0]  REQ_UNUSED   = 2'd3;
   localparam logic [15:0] ADDR_ENABLE  = 16'h0000;
   localparam logic [15:0] ADDR_ROMBNK  = 16'h2000;
   localparam logic [15:0] ADDR_ROMX    = 16'h4000;
   localparam logic [15:0] ADDR_LATCH   = 16'h6000;
   localparam logic [15:0] ADDR_VRAM    = 16'h8000;
   localparam logic [15:0] ADDR_WINDOW  = 16'hA000;
   localparam logic [15:0] ADDR_WRAM    = 16'hC000;
   localparam logic [15:0] ADDR_TOP     = 16'hFFFF;
   localparam int          RANDOM_BEATS = 1750;
   localparam int          CALM_TAIL    = 150;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          STALL_LIMIT  = 150000;
   localparam int          REPORT_LINES = 100;

   typedef enum logic [1:0] {WIN_RAM, WIN_RTC, WIN_NONE} window_t;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [20:0] rom_pos;
      logic [5:0]  now_sec;
      logic [5:0]  now_min;
      logic [4:0]  now_hour;
      logic [8:0]  now_day;
      bit          drain_first;
   } bus_beat_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // bank model
   logic       m_ram_en;
   logic [6:0] m_rom_bank;
   logic [1:0] m_ram_bank;
   logic [3:0] m_rtc_sel;
   window_t    m_window;
   logic [5:0] m_sec;
   logic [5:0] m_min;
   logic [4:0] m_hour;
   logic [8:0] m_day;
   logic [7:0] m_save_ram [RAM_TOTAL];
   logic [7:0] m_rom_image [int];

   logic [7:0] read_bytes_due [$];

   // stimulus side
   bus_beat_t  beats_pending [$];
   bus_beat_t  live_beat;
   bit         rom_loaded [int];
   int         loaded_list [$];
   logic [6:0] gen_bank = 7'd1;
   int         gen_count = 0;

   bit beat_taken     = 1'b0;
   bit hold_for_drain = 1'b0;
   bit stim_done      = 1'b0;
   int send_gap       = 0;
   int ready_gap      = 0;
   int idle_pct       = 15;
   int phase_cycles   = 0;
   int stall_cycles   = 0;
   int mismatches     = 0;
   int reads_checked  = 0;
   int reads_sent     = 0;
   int writes_sent    = 0;
   int preloads_sent  = 0;

   cartridge_bank_controller_rtc u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int ram_index(input logic [15:0] addr);
      return int'(m_ram_bank % RAM_BANKS) * RAM_BANK_BYTES
             + ((int'(addr) - int'(ADDR_WINDOW)) & (RAM_BANK_BYTES - 1));
   endfunction

   function automatic logic [7:0] rom_lookup(input int pos);
      return m_rom_image.exists(pos) ? m_rom_image[pos] : 8'h00;
   endfunction

   function automatic void predict_access(input bus_beat_t bt);
      logic [7:0] rd;
      logic [6:0] bk;
      case (bt.kind)
         REQ_READ: begin
            rd = OPEN_BUS;
            if (bt.addr < ADDR_ROMX) begin
               rd = rom_lookup(int'(bt.addr));
            end else if (bt.addr < ADDR_VRAM) begin
               rd = rom_lookup(int'(m_rom_bank % ROM_BANKS) * ROM_BANK_BYTES
                               + int'(bt.addr) - int'(ADDR_ROMX));
            end else if (bt.addr >= ADDR_WINDOW && bt.addr < ADDR_WRAM && m_ram_en) begin
               if (m_window == WIN_RAM) begin
                  rd = m_save_ram[ram_index(bt.addr)];
               end else if (m_window == WIN_RTC) begin
                  case (m_rtc_sel)
                     RTC_SEC:  rd = {2'b00, m_sec};
                     RTC_MIN:  rd = {2'b00, m_min};
                     RTC_HOUR: rd = {3'b000, m_hour};
                     RTC_DAYL: rd = m_day[7:0];
                     RTC_DAYH: rd = {7'd0, m_day[8]};
                     default:  rd = 8'h00;
                  endcase
               end
            end
            read_bytes_due.push_back(rd);
         end
         REQ_WRITE: begin
            if (bt.addr < ADDR_ROMBNK) begin
               m_ram_en = (bt.data == ENABLE_KEY);
            end else if (bt.addr < ADDR_ROMX) begin
               bk = bt.data[6:0];
               m_rom_bank = (bk == 7'd0) ? 7'd1 : bk;
            end else if (bt.addr < ADDR_LATCH) begin
               if (bt.data < SEL_RTC_LO) begin
                  m_window   = WIN_RAM;
                  m_ram_bank = bt.data[1:0];
               end else if (bt.data < SEL_NONE_LO) begin
                  m_window  = WIN_RTC;
                  m_rtc_sel = bt.data[3:0];
               end else begin
                  m_window = WIN_NONE;
               end
            end else if (bt.addr < ADDR_VRAM) begin
               if (bt.data == LATCH_KEY) begin
                  m_sec  = bt.now_sec;
                  m_min  = bt.now_min;
                  m_hour = bt.now_hour;
                  m_day  = bt.now_day;
               end
            end else if (bt.addr >= ADDR_WINDOW && bt.addr < ADDR_WRAM && m_ram_en
                         && m_window == WIN_RAM) begin
               m_save_ram[ram_index(bt.addr)] = bt.data;
            end
         end
         REQ_PRELOAD: begin
            if (int'(bt.rom_pos) < ROM_TOTAL) m_rom_image[int'(bt.rom_pos)] = bt.data;
         end
         default: ;
      endcase
   endfunction

   function automatic bus_beat_t make_beat(input logic [1:0] kind, input logic [15:0] addr,
                                           input logic [7:0] data, input logic [20:0] pos);
      bus_beat_t b;
      b.kind        = kind;
      b.addr        = addr;
      b.data        = data;
      b.rom_pos     = pos;
      b.now_sec     = 6'($urandom_range(60, 0));
      b.now_min     = 6'($urandom_range(59, 0));
      b.now_hour    = 5'($urandom_range(23, 0));
      b.now_day     = 9'($urandom_range(511, 0));
      b.drain_first = 1'b0;
      return b;
   endfunction

   task automatic enqueue(input bus_beat_t b);
      beats_pending.push_back(b);
      if (b.kind != REQ_UNUSED && !b.drain_first) gen_count++;
      if (b.kind == REQ_PRELOAD && !rom_loaded.exists(int'(b.rom_pos))) begin
         rom_loaded[int'(b.rom_pos)] = 1'b1;
         loaded_list.push_back(int'(b.rom_pos));
      end
      if (b.kind == REQ_WRITE && b.addr >= ADDR_ROMBNK && b.addr < ADDR_ROMX)
         gen_bank = (b.data[6:0] == 7'd0) ? 7'd1 : b.data[6:0];
   endtask

   task automatic reg_write(input logic [15:0] lo, input logic [15:0] hi, input logic [7:0] v);
      enqueue(make_beat(REQ_WRITE, 16'($urandom_range(hi, lo)), v, 21'($urandom)));
   endtask

   // preload the ROM byte first if it was never written
   task automatic read_at(input logic [15:0] addr);
      int pos;
      if (addr < ADDR_VRAM) begin
         pos = (addr < ADDR_ROMX) ? int'(addr)
               : int'(gen_bank % ROM_BANKS) * ROM_BANK_BYTES + int'(addr) - int'(ADDR_ROMX);
         if (!rom_loaded.exists(pos))
            enqueue(make_beat(REQ_PRELOAD, 16'($urandom), 8'($urandom), 21'(pos)));
      end
      enqueue(make_beat(REQ_READ, addr, 8'($urandom), 21'($urandom)));
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      if (mismatches <= REPORT_LINES)
         $display("mismatch %s: got %02h, want %02h, after %0d reads checked",
                  what, got, want, reads_checked);
   endtask

   // driver: present beats at the falling edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) beat_taken = 1'b1;
      phase_cycles++;
      if (phase_cycles % 64 == 0) begin
         case ($urandom_range(2, 0))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 45;
         endcase
      end
   end

   always @(negedge clock) begin
      if (beat_taken) begin
         predict_access(live_beat);
         case (live_beat.kind)
            REQ_READ:    reads_sent++;
            REQ_WRITE:   writes_sent++;
            REQ_PRELOAD: preloads_sent++;
            default: ;
         endcase
      end
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beat_taken) begin
         beat_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (hold_for_drain) begin
            if (read_bytes_due.size() == 0) hold_for_drain = 1'b0;
            req_tvalid <= 1'b0;
         end else if (beats_pending.size() == 0) begin
            stim_done = 1'b1;
            req_tvalid <= 1'b0;
         end else if (beats_pending.size() >= CALM_TAIL
                      && $urandom_range(99, 0) < idle_pct) begin
            send_gap = $urandom_range(2, 0);
            req_tvalid <= 1'b0;
         end else begin
            live_beat = beats_pending.pop_front();
            if (live_beat.drain_first) begin
               hold_for_drain = 1'b1;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser  <= live_beat.kind;
               req_tdata  <= {1'b0, live_beat.now_day, live_beat.now_hour, live_beat.now_min,
                              live_beat.now_sec, live_beat.rom_pos, live_beat.data,
                              live_beat.addr};
            end
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (ready_gap > 0) begin
         ready_gap--;
         rsp_tready <= 1'b0;
      end else if (beats_pending.size() >= CALM_TAIL && $urandom_range(99, 0) < idle_pct) begin
         ready_gap = $urandom_range(2, 0);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (read_bytes_due.size() == 0) begin
            report_mismatch("read_data with no read pending", rsp_tdata, 8'h00);
         end else begin
            want = read_bytes_due.pop_front();
            if (rsp_tdata !== want) report_mismatch("read_data", rsp_tdata, want);
         end
         reads_checked++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("no beat moved for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int         pick;
      int         n;
      int         pos;
      logic [15:0] a;
      logic [15:0] ram_addrs [$];
      bus_beat_t  b;

      m_ram_en   = 1'b0;
      m_rom_bank = 7'd1;
      m_ram_bank = 2'd0;
      m_rtc_sel  = 4'd0;
      m_window   = WIN_RAM;
      m_sec      = '0;
      m_min      = '0;
      m_hour     = '0;
      m_day      = '0;
      for (int i = 0; i < RAM_TOTAL; i++) m_save_ram[i] = 8'h00;

      // directed: disabled window, RAM banks, clock registers, bank zero, unmapped
      read_at(ADDR_WINDOW);
      reg_write(ADDR_ENABLE, ADDR_ENABLE, ENABLE_KEY);
      reg_write(ADDR_WRAM - 1, ADDR_WRAM - 1, 8'hFF);
      read_at(ADDR_WRAM - 1);
      reg_write(ADDR_ROMX, ADDR_ROMX, 8'd3);
      reg_write(ADDR_WINDOW, ADDR_WINDOW, 8'h5A);
      read_at(ADDR_WINDOW);
      reg_write(ADDR_LATCH - 1, ADDR_LATCH - 1, 8'd0);
      read_at(ADDR_WINDOW);
      b = make_beat(REQ_WRITE, ADDR_LATCH, LATCH_KEY, 21'($urandom));
      b.now_sec  = 6'd60;
      b.now_min  = 6'd59;
      b.now_hour = 5'd23;
      b.now_day  = 9'd511;
      enqueue(b);
      for (int s = RTC_SEC; s <= RTC_DAYH; s++) begin
         reg_write(ADDR_ROMX, ADDR_LATCH - 1, 8'(s));
         read_at(ADDR_WINDOW);
      end
      reg_write(ADDR_WINDOW, ADDR_WINDOW, 8'h33);
      read_at(ADDR_WINDOW);
      reg_write(ADDR_ROMX, ADDR_ROMX, SEL_RTC_LO);
      read_at(ADDR_WRAM - 1);
      reg_write(ADDR_ROMX, ADDR_ROMX, SEL_NONE_LO);
      read_at(ADDR_WINDOW);
      reg_write(ADDR_ROMBNK, ADDR_ROMBNK, 8'h00);
      read_at(ADDR_ROMX);
      reg_write(ADDR_ROMX - 1, ADDR_ROMX - 1, 8'h7F);
      read_at(ADDR_VRAM - 1);
      reg_write(ADDR_ROMBNK, ADDR_ROMBNK, 8'h80);
      read_at(ADDR_ENABLE);
      read_at(ADDR_ROMX - 1);
      read_at(ADDR_VRAM);
      reg_write(ADDR_WINDOW - 1, ADDR_WINDOW - 1, 8'hA5);
      read_at(ADDR_WRAM);
      read_at(ADDR_TOP);
      enqueue(make_beat(REQ_UNUSED, 16'($urandom), 8'($urandom), 21'($urandom)));
      reg_write(ADDR_ENABLE, ADDR_ROMBNK - 1, 8'h0B);
      reg_write(ADDR_LATCH, ADDR_VRAM - 1, 8'h00);
      reg_write(ADDR_ROMX, ADDR_LATCH - 1, 8'd0);
      read_at(ADDR_WINDOW);
      b = make_beat(REQ_READ, '0, '0, '0);
      b.drain_first = 1'b1;
      enqueue(b);

      // random sequences
      n = gen_count + RANDOM_BEATS;
      while (gen_count < n) begin
         pick = $urandom_range(99, 0);
         if (gen_count > n - RANDOM_BEATS / 2 && gen_count < n - RANDOM_BEATS / 2 + 8) begin
            b = make_beat(REQ_READ, '0, '0, '0);
            b.drain_first = 1'b1;
            enqueue(b);
         end
         if (pick < 20) begin
            repeat ($urandom_range(4, 1)) read_at(16'($urandom_range(ADDR_VRAM - 1, 0)));
         end else if (pick < 30) begin
            reg_write(ADDR_ROMBNK, ADDR_ROMX - 1, 8'($urandom));
            repeat ($urandom_range(3, 1)) read_at(16'($urandom_range(ADDR_VRAM - 1, ADDR_ROMX)));
         end else if (pick < 40) begin
            pos = loaded_list[$urandom_range(loaded_list.size() - 1, 0)];
            if (pos < ROM_BANK_BYTES) begin
               read_at(16'(pos));
            end else begin
               reg_write(ADDR_ROMBNK, ADDR_ROMX - 1, {1'($urandom), 7'(pos >> 14)});
               read_at(ADDR_ROMX + 16'(pos % ROM_BANK_BYTES));
            end
         end else if (pick < 60) begin
            if ($urandom_range(99, 0) < 85) reg_write(ADDR_ENABLE, ADDR_ROMBNK - 1, ENABLE_KEY);
            reg_write(ADDR_ROMX, ADDR_LATCH - 1, 8'($urandom_range(3, 0)));
            ram_addrs.delete();
            repeat ($urandom_range(4, 1)) begin
               a = 16'($urandom_range(ADDR_WRAM - 1, ADDR_WINDOW));
               ram_addrs.push_back(a);
               reg_write(a, a, 8'($urandom));
            end
            foreach (ram_addrs[i]) if ($urandom_range(3, 0) != 0) read_at(ram_addrs[i]);
            read_at(16'($urandom_range(ADDR_WRAM - 1, ADDR_WINDOW)));
         end else if (pick < 75) begin
            reg_write(ADDR_LATCH, ADDR_VRAM - 1, LATCH_KEY);
            if ($urandom_range(3, 0) == 0)
               reg_write(ADDR_ROMX, ADDR_LATCH - 1, 8'($urandom_range(SEL_NONE_LO - 1, SEL_RTC_LO)));
            else
               reg_write(ADDR_ROMX, ADDR_LATCH - 1, 8'($urandom_range(RTC_DAYH, RTC_SEC)));
            repeat ($urandom_range(2, 1)) read_at(16'($urandom_range(ADDR_WRAM - 1, ADDR_WINDOW)));
            if ($urandom_range(1, 0)) begin
               reg_write(ADDR_WINDOW, ADDR_WRAM - 1, 8'($urandom));
               read_at(16'($urandom_range(ADDR_WRAM - 1, ADDR_WINDOW)));
            end
         end else if (pick < 85) begin
            case ($urandom_range(2, 0))
               0:       reg_write(ADDR_ENABLE, ADDR_ROMBNK - 1, 8'($urandom));
               1:       reg_write(ADDR_LATCH, ADDR_VRAM - 1, 8'($urandom_range(255, 2)));
               default: reg_write(ADDR_ROMX, ADDR_LATCH - 1, 8'($urandom_range(255, SEL_NONE_LO)));
            endcase
            read_at(16'($urandom_range(ADDR_WRAM - 1, ADDR_WINDOW)));
         end else if (pick < 92) begin
            repeat ($urandom_range(3, 1))
               enqueue(make_beat(REQ_PRELOAD, 16'($urandom), 8'($urandom), 21'($urandom)));
         end else begin
            b = make_beat(2'($urandom_range(3, 0)), 16'($urandom), 8'($urandom), 21'($urandom));
            if (b.kind == REQ_READ) read_at(b.addr);
            else enqueue(b);
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (stim_done);
      while (read_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bus reads, %0d bus writes, %0d ROM preloads",
               reads_sent, writes_sent, preloads_sent);
      $display("checked %0d read bytes, %0d mismatches", reads_checked, mismatches);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
